FILE: src/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication with the consequent checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/crki_pkg.sv
package crki_pkg;

  localparam int unsigned MaxPointsDefault = 32;

  typedef struct packed {
    logic        command;
    logic [4:0]  point_index;
    logic [15:0] point_time;
    logic [31:0] point_value;
    logic [15:0] query_time;
  } crki_in_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic        clamped;
  } crki_out_t;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_LD_P0,
    ST_LD_P1,
    ST_LD_P2,
    ST_LD_P3,
    ST_LD_WAIT,
    ST_DIV,
    ST_MUL,
    ST_FINISH,
    ST_DONE
  } crki_state_t;

  // multiply step opcodes for the shared multiplier
  typedef enum logic [3:0] {
    MS_AA,     // a*a
    MS_TT,     // t*t
    MS_H00,    // (s+2t)*aa
    MS_H10,    // t*aa
    MS_H01,    // tt*(3s-2t)
    MS_H11,    // tt*(t-s)
    MS_A0,     // h00*2*p1
    MS_A1,     // h10*m1
    MS_A2,     // h01*2*p2
    MS_A3      // h11*m2
  } crki_mstep_t;

endpackage

FILE: src/catmull_rom_keyframe_interpolator_core.sv
// channel | ports                          | direction
// input   | start, busy, in_item           | start with busy low is a transfer
// result  | out_valid, out_item            | one cycle strobe, no back pressure
// config  | cfg_we, cfg_data               | point_count, write only while idle
// a write item goes from the accept through the done state; a query reads and
// checks each searched key, makes four table reads (keys i-2 to i+1), runs the
// divide and 10 shared multiply steps, then finish and strobe; a query outside
// the keys skips the divide and the multiplies
// reset is synchronous, active low; the key tables are not cleared
// busy stays high from a transfer until its result strobe (or write end);
// the receiver cannot stall, so nothing else holds the block
`include "assert_macros.svh"
module catmull_rom_keyframe_interpolator_core
  import crki_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MaxPointsDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  crki_in_t  in_item,
  output logic      out_valid,
  output crki_out_t out_item,
  input  logic      cfg_we,
  input  logic [5:0] cfg_data
);
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  logic [15:0] time_mem [MAX_POINTS];
  logic [31:0] val_mem  [MAX_POINTS];
  logic [15:0] time_rd_r;
  logic [31:0] val_rd_r;

  logic [5:0] cnt_cfg_r;
  crki_state_t st_r, st_nxt;
  crki_in_t    item_r;
  logic [CW-1:0] n_keys, idx_r, idx_nxt, i_r;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic          in_accept;
  logic [15:0]   t1_r, t2_r;
  logic signed [32:0] p0_r, p1_r, p2_r, p3_r;
  logic [16:0]   tq_r;
  crki_mstep_t   ms_r;
  logic signed [35:0] tt_r, aa_r;
  logic signed [17:0] h00_r, h10_r, h01_r, h11_r;
  logic signed [67:0] acc_r;
  logic [31:0] res_r;
  logic        clamp_r, out_v_r;
  logic        div_start, div_done;
  logic [16:0] div_q;

  assign in_accept = start && !busy;

  // clamp point_count into range
  always_comb begin
    if (cnt_cfg_r < 6'd2) n_keys = CW'(2);
    else if ({26'd0, cnt_cfg_r} > 32'(MAX_POINTS)) n_keys = CW'(MAX_POINTS);
    else n_keys = CW'(cnt_cfg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_cfg_r <= 6'd2;
    else if (cfg_we) cnt_cfg_r <= cfg_data;
  end

  // memory: one write port, one registered read port
  assign mem_we = in_accept && (in_item.command == CmdWrite) &&
                  ({27'd0, in_item.point_index} < 32'(MAX_POINTS));
  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[AW'(in_item.point_index)] <= in_item.point_time;
      val_mem[AW'(in_item.point_index)]  <= in_item.point_value;
    end
    time_rd_r <= time_mem[raddr];
    val_rd_r  <= val_mem[raddr];
  end

  function automatic logic [15:0] q_minus_t1(input logic [15:0] q, input logic [15:0] t);
    return q - t;
  endfunction

  crki_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend({q_minus_t1(item_r.query_time, t1_r), 16'd0}),
    .divisor(t2_r - t1_r), .done(div_done), .quotient(div_q)
  );

  function automatic logic signed [33:0] m1_val();
    if (i_r >= CW'(2)) return 34'(p2_r) - 34'(p0_r);
    return (34'(p2_r) - 34'(p1_r)) <<< 1;
  endfunction
  function automatic logic signed [33:0] m2_val();
    if ((32'(i_r) + 1) < 32'(n_keys)) return 34'(p3_r) - 34'(p1_r);
    return (34'(p2_r) - 34'(p1_r)) <<< 1;
  endfunction

  // shared multiplier operand selection
  logic signed [35:0] ma;
  logic signed [33:0] mb;
  logic signed [69:0] mprod;
  logic signed [17:0] s_t;
  always_comb begin
    s_t = $signed({1'b0, tq_r});
    ma = '0;
    mb = '0;
    case (ms_r)
      MS_AA:  begin ma = 36'(18'sd65536 - s_t); mb = 34'(18'sd65536 - s_t); end
      MS_TT:  begin ma = 36'(s_t); mb = 34'(s_t); end
      MS_H00: begin ma = aa_r; mb = 34'(19'sd65536 + 19'(s_t) * 2); end
      MS_H10: begin ma = aa_r; mb = 34'(s_t); end
      MS_H01: begin ma = tt_r; mb = 34'(19'sd196608 - 19'(s_t) * 2); end
      MS_H11: begin ma = tt_r; mb = 34'(s_t - 18'sd65536); end
      MS_A0:  begin ma = 36'(h00_r); mb = 34'(p1_r) <<< 1; end
      MS_A1:  begin ma = 36'(h10_r); mb = m1_val(); end
      MS_A2:  begin ma = 36'(h01_r); mb = 34'(p2_r) <<< 1; end
      default: begin ma = 36'(h11_r); mb = m2_val(); end
    endcase
    mprod = 70'(ma) * 70'(mb);
  end

  // rounded basis weight from the product
  logic signed [17:0] hround;
  logic signed [63:0] hsum;
  assign hsum = mprod[63:0] + 64'sd2147483648;
  assign hround = hsum[49:32];

  // final rounding; the finish state saturates fsh
  logic signed [67:0] fin;
  logic signed [50:0] fsh;
  assign fin = acc_r + 68'sd65536;
  assign fsh = fin[67:17];

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    raddr = AW'(idx_r);
    div_start = 1'b0;
    case (st_r)
      ST_IDLE: begin
        idx_nxt = '0;
        raddr = '0;
        if (in_accept) st_nxt = (in_item.command == CmdQuery) ? ST_SRCH_RD : ST_DONE;
      end
      ST_SRCH_RD: st_nxt = ST_SRCH_CHK;
      ST_SRCH_CHK: begin
        if (time_rd_r >= item_r.query_time) begin
          st_nxt = ST_LD_P0;
        end else if (idx_r + CW'(1) >= n_keys) begin
          idx_nxt = idx_r + CW'(1);
          st_nxt = ST_LD_P0;
        end else begin
          idx_nxt = idx_r + CW'(1);
          raddr = AW'(idx_nxt);
          st_nxt = ST_SRCH_RD;
        end
      end
      ST_LD_P0, ST_LD_P1, ST_LD_P2, ST_LD_P3, ST_LD_WAIT: begin
        // read i-2, i-1, i, i+1 in turn
        case (st_r)
          ST_LD_P0: begin raddr = AW'(i_r - CW'(2)); st_nxt = ST_LD_P1; end
          ST_LD_P1: begin raddr = AW'(i_r - CW'(1)); st_nxt = ST_LD_P2; end
          ST_LD_P2: begin raddr = AW'(i_r); st_nxt = ST_LD_P3; end
          ST_LD_P3: begin raddr = AW'(i_r + CW'(1)); st_nxt = ST_LD_WAIT; end
          default: st_nxt = (i_r == '0 || i_r >= n_keys) ? ST_FINISH : ST_DIV;
        endcase
        if (st_r == ST_LD_WAIT && st_nxt == ST_DIV) div_start = 1'b1;
      end
      ST_DIV: if (div_done) st_nxt = ST_MUL;
      ST_MUL: if (ms_r == MS_A3) st_nxt = ST_FINISH;
      ST_FINISH: st_nxt = ST_IDLE;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_v_r <= (st_r == ST_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (in_accept) item_r <= in_item;
    if (st_r == ST_SRCH_CHK && st_nxt == ST_LD_P0) i_r <= idx_nxt;
    // captured from the registered read data in the state after each address
    case (st_r)
      ST_LD_P1: p0_r <= 33'(signed'(val_rd_r));
      ST_LD_P2: begin p1_r <= 33'(signed'(val_rd_r)); t1_r <= time_rd_r; end
      ST_LD_P3: begin p2_r <= 33'(signed'(val_rd_r)); t2_r <= time_rd_r; end
      ST_LD_WAIT: p3_r <= 33'(signed'(val_rd_r));
      default: ;
    endcase
    if (st_r == ST_DIV && div_done) begin
      tq_r <= div_q;
      ms_r <= MS_AA;
      acc_r <= '0;
    end
    if (st_r == ST_MUL) begin
      case (ms_r)
        MS_AA:  begin aa_r <= mprod[35:0]; ms_r <= MS_TT; end
        MS_TT:  begin tt_r <= mprod[35:0]; ms_r <= MS_H00; end
        MS_H00: begin h00_r <= hround; ms_r <= MS_H10; end
        MS_H10: begin h10_r <= hround; ms_r <= MS_H01; end
        MS_H01: begin h01_r <= hround; ms_r <= MS_H11; end
        MS_H11: begin h11_r <= hround; ms_r <= MS_A0; end
        MS_A0:  begin acc_r <= acc_r + 68'(mprod); ms_r <= MS_A1; end
        MS_A1:  begin acc_r <= acc_r + 68'(mprod); ms_r <= MS_A2; end
        MS_A2:  begin acc_r <= acc_r + 68'(mprod); ms_r <= MS_A3; end
        default: acc_r <= acc_r + 68'(mprod);
      endcase
    end
    if (st_r == ST_FINISH) begin
      if (i_r == '0) begin
        res_r <= p2_r[31:0];
        clamp_r <= item_r.query_time < t2_r;
      end else if (i_r >= n_keys) begin
        res_r <= p1_r[31:0];
        clamp_r <= 1'b1;
      end else if (fsh > 51'sd2147483647) begin
        res_r <= 32'h7fffffff;
        clamp_r <= 1'b1;
      end else if (fsh < -51'sd2147483648) begin
        res_r <= 32'h80000000;
        clamp_r <= 1'b1;
      end else begin
        res_r <= fsh[31:0];
        clamp_r <= 1'b0;
      end
    end
  end

  assign busy = (st_r != ST_IDLE) || out_v_r;
  assign out_valid = out_v_r;
  assign out_item.result_value = res_r;
  assign out_item.clamped = clamp_r;

  `ASSERT_NEXT(a_start_leaves_idle, clk, rst_n, start && !busy, st_r != ST_IDLE)
  `ASSERT_IMPL(a_out_only_after_finish, clk, rst_n, out_valid, $past(st_r) == ST_FINISH)
  `ASSERT_IMPL(a_div_in_div_state, clk, rst_n, div_done, st_r == ST_DIV)
endmodule

FILE: src/crki_divider.sv
module crki_divider
  import crki_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [16:0] quotient
);
  // restoring divide, one quotient bit per cycle, 32 bits
  logic [31:0] num_r, num_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic [16:0] trial;

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    trial = {rem_r[15:0], num_r[31]};
    if (start) begin
      num_nxt = dividend;
      rem_nxt = '0;
      quo_nxt = '0;
      cnt_nxt = 6'd32;
      run_nxt = 1'b1;
    end else if (run_r) begin
      num_nxt = {num_r[30:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = trial - {1'b0, divisor};
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done = run_r && (cnt_r == 6'd1);
  // quotient fits in 17 bits as q - t1 <= t2 - t1
  assign quotient = quo_nxt[16:0];
endmodule

FILE: dv/tb_catmull_rom_keyframe_interpolator_core.sv
`timescale 1ns / 1ps
module tb_catmull_rom_keyframe_interpolator_core;
  import crki_pkg::*;

  localparam int NumKeys = 32;
  localparam int DrainCycles = 160;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  crki_in_t  in_item;
  logic      out_valid;
  crki_out_t out_item;
  logic      cfg_we;
  logic [5:0] cfg_data;

  catmull_rom_keyframe_interpolator_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // local copy of the key tables and the count register
  logic [15:0] key_time_tbl [NumKeys];
  longint      key_value_tbl [NumKeys];
  logic [5:0]  point_count;

  crki_out_t expected_results [$];
  int        mismatch_count;
  int        burst_left;
  logic [15:0] seq_first;
  logic [15:0] seq_last;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12ns * 1_500_000);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint round_weight(longint n);
    return (n + 64'sd2147483648) >>> 32;
  endfunction

  function automatic crki_out_t predict_spline(logic [15:0] q);
    crki_out_t r;
    int n, i;
    longint res, p1, p2, m1, m2, tw, aw, h00, h10, h01, h11, acc;
    longint t1, t2;
    logic clamp;
    n = (point_count < 2) ? 2 : ((point_count > NumKeys) ? NumKeys : int'(point_count));
    i = 0;
    clamp = 1'b0;
    while (i < n && key_time_tbl[i] < q) i++;
    if (i == 0) begin
      res = key_value_tbl[0];
      clamp = (q < key_time_tbl[0]);
    end else if (i >= n) begin
      res = key_value_tbl[n-1];
      clamp = 1'b1;
    end else begin
      t1 = key_time_tbl[i-1];
      t2 = key_time_tbl[i];
      p1 = key_value_tbl[i-1];
      p2 = key_value_tbl[i];
      if (t2 <= t1) begin
        res = p2;
      end else begin
        tw = ((longint'(q) - t1) <<< 16) / (t2 - t1);
        aw = 65536 - tw;
        m1 = (i >= 2) ? (p2 - key_value_tbl[i-2]) : 2 * (p2 - p1);
        m2 = (i + 1 < n) ? (key_value_tbl[i+1] - p1) : 2 * (p2 - p1);
        h00 = round_weight((65536 + 2 * tw) * aw * aw);
        h10 = round_weight(tw * aw * aw);
        h01 = round_weight(tw * tw * (3 * 65536 - 2 * tw));
        h11 = round_weight(tw * tw * (tw - 65536));
        acc = 2 * h00 * p1 + h10 * m1 + 2 * h01 * p2 + h11 * m2;
        res = (acc + 65536) >>> 17;
      end
    end
    if (res > 64'sd2147483647) begin
      res = 64'sd2147483647;
      clamp = 1'b1;
    end else if (res < -64'sd2147483648) begin
      res = -64'sd2147483648;
      clamp = 1'b1;
    end
    r.result_value = res[31:0];
    r.clamped = clamp;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    $display("mismatch %s: expected %h got %h at %0t", what, exp_v, got_v, $realtime);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    crki_out_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'h0, out_item.result_value);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_item.result_value !== exp_r.result_value)
          report_mismatch("result_value", exp_r.result_value, out_item.result_value);
        if (out_item.clamped !== exp_r.clamped)
          report_mismatch("clamped", 32'(exp_r.clamped), 32'(out_item.clamped));
      end
    end
  end

  // one transfer; start stays high when the burst goes on
  task automatic send_item(crki_in_t it);
    int gap;
    in_item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.command == CmdWrite) begin
      key_time_tbl[it.point_index] = it.point_time;
      key_value_tbl[it.point_index] = longint'($signed(it.point_value));
    end else begin
      expected_results.push_back(predict_spline(it.query_time));
    end
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_key(int idx, logic [15:0] t, logic [31:0] v);
    crki_in_t it;
    it = '0;
    it.command = CmdWrite;
    it.point_index = idx[4:0];
    it.point_time = t;
    it.point_value = v;
    it.query_time = 16'($urandom);
    send_item(it);
  endtask

  task automatic query_at(logic [15:0] q);
    crki_in_t it;
    it.command = CmdQuery;
    it.point_index = 5'($urandom);
    it.point_time = 16'($urandom);
    it.point_value = $urandom;
    it.query_time = q;
    send_item(it);
  endtask

  // waits out all results and a drain for any item still in flight, then writes the count
  task automatic set_point_count(logic [5:0] v);
    @(posedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    point_count = v;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // sorted keys in the slots in use, random content
  task automatic load_sorted_keys(int n);
    int step_max, t;
    step_max = 60000 / n;
    t = $urandom_range(1, 3000);
    seq_first = t[15:0];
    for (int k = 0; k < n; k++) begin
      write_key(k, t[15:0], random_value());
      seq_last = t[15:0];
      t += $urandom_range(1, step_max);
    end
  endtask

  task automatic test_fill_table();
    for (int k = 0; k < NumKeys; k++)
      write_key(k, 16'(100 + k * 2000), random_value());
    seq_first = 16'd100;
    seq_last = 16'(100 + 31 * 2000);
  endtask

  task automatic test_special_cases();
    set_point_count(6'd4);
    write_key(0, 16'd1000, 32'h0001_0000);
    write_key(1, 16'd2000, 32'h7fff_ffff);
    write_key(2, 16'd2001, 32'h8000_0000);
    write_key(3, 16'd65534, 32'h7fff_ffff);
    query_at(16'd0);        // before first key
    query_at(16'd1000);     // on first key
    query_at(16'd1500);
    query_at(16'd2000);
    query_at(16'd2001);
    query_at(16'd1999);     // overshoot toward saturation
    query_at(16'd40000);
    query_at(16'd65534);
    query_at(16'd65535);    // past last key
    write_key(0, 16'd0, 32'h8000_0000);
    write_key(1, 16'd1, 32'h7fff_ffff);
    write_key(2, 16'hffff, 32'h8000_0000);
    query_at(16'd0);
    query_at(16'd1);
    query_at(16'h8000);
    query_at(16'hffff);
  endtask

  task automatic test_count_extremes();
    set_point_count(6'd0);   // acts as two keys
    query_at(16'd0);
    query_at(16'd30);
    query_at(16'hffff);
    set_point_count(6'd63);  // acts as full table
    query_at(16'd20000);
    query_at(16'hffff);
  endtask

  task automatic test_random_phase(logic [5:0] cnt, int items);
    int n, lo, hi;
    set_point_count(cnt);
    n = (cnt < 2) ? 2 : ((cnt > NumKeys) ? NumKeys : int'(cnt));
    load_sorted_keys(n);
    for (int j = 0; j < items; j++) begin
      case ($urandom_range(0, 19))
        0: write_key($urandom_range(0, NumKeys - 1), 16'($urandom), random_value());
        1: query_at(16'($urandom));
        2: load_sorted_keys(n);
        default: begin
          lo = (seq_first > 50) ? seq_first - 50 : 0;
          hi = (seq_last < 65485) ? seq_last + 50 : 65535;
          query_at(16'($urandom_range(lo, hi)));
        end
      endcase
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    point_count = 6'd2;
    mismatch_count = 0;
    burst_left = 4;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_table();
    test_special_cases();
    test_count_extremes();
    test_random_phase(6'd2, 40);
    test_random_phase(6'd32, 60);
    test_random_phase(6'd3, 40);
    test_random_phase(6'($urandom_range(4, 31)), 50);
    test_random_phase(6'($urandom_range(4, 31)), 50);
    test_random_phase(6'd1, 30);
    test_random_phase(6'd45, 40);
    test_random_phase(6'd17, 50);
    @(posedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/crki_pkg.sv
src/crki_divider.sv
src/catmull_rom_keyframe_interpolator_core.sv
dv/tb_catmull_rom_keyframe_interpolator_core.sv
